// ===== hdl/efvs_pkg.sv =====
// Shared types and codes for the earliest-finish machine scheduler.
// No dependencies; imported by every module of the block.
`default_nettype none
package efvs_pkg;
	localparam int MAX_MACHINES_DEF  = 16;
	localparam int MAX_CORES_DEF     = 16;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int MIDX_W = 6;
	localparam int NW     = 7;
	localparam logic [47:0] FIN_MAX = 48'hFFFF_FFFF_FFFF;

	typedef enum logic [1:0] {
		CMD_ADD   = 2'd0,
		CMD_SCHED = 2'd1,
		CMD_CLEAR = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_NONE  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_MUL, S_DIV, S_CHAIN, S_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [3:0]  machine_index;
		logic [15:0] core_speed;
		logic [30:0] instruction_count;
		logic [30:0] start_time;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [3:0]         chosen_machine;
		logic [47:0]        finish_time;
		logic signed [47:0] response_time;
	} out_beat_t;

	typedef struct packed {
		logic add;
		logic clr;
		logic load;
		logic step;
		logic wr;
	} cell_ctrl_t;

	typedef struct packed {
		logic              found;
		logic [MIDX_W-1:0] idx;
		logic [47:0]       fin;
	} best_t;
endpackage
`default_nettype wire

// ===== hdl/efvs_cell.sv =====
// One machine entry: core count, speed sum, finish time and a bit-serial divider.
// Passes the running best candidate to its neighbor. Uses efvs_pkg.
`default_nettype none
module efvs_cell #(
	parameter int CELL_IDX      = 0,
	parameter int MAX_CORES     = efvs_pkg::MAX_CORES_DEF,
	parameter int FRACTION_BITS = efvs_pkg::FRACTION_BITS_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  efvs_pkg::cell_ctrl_t             ctrl,
	input  wire  [3:0]                       add_idx,
	input  wire  [15:0]                      speed,
	input  wire  [30:0]                      instr,
	input  wire  [efvs_pkg::MIDX_W-1:0]      wr_idx,
	input  wire  [47:0]                      wr_fin,
	input  wire  [efvs_pkg::NW-1:0]          n_used,
	input  efvs_pkg::best_t                  best_in,
	output efvs_pkg::best_t                  best_out,
	output logic                             full
);
	import efvs_pkg::*;

	localparam int CW = $clog2(MAX_CORES + 1);
	localparam int PW = 31 + CW;
	localparam int DW = PW + FRACTION_BITS;
	localparam int RW = DW + 21;
	localparam int SW = ((DW > 48) ? DW : 48) + 1;

	logic [CW-1:0] cores_q;
	logic [19:0]   sum_q;
	logic [47:0]   fin_q;
	logic [RW-1:0] rq_q;
	best_t         best_q;

	logic          here;
	logic [20:0]   sum_add;
	logic [PW-1:0] prod;
	logic [RW-1:0] shifted;
	logic [20:0]   hi;
	logic [RW-1:0] rq_next;
	logic [SW-1:0] tot;
	logic [47:0]   cand;
	logic          usable;
	best_t         best_d;

	assign here    = ({3'b000, add_idx} == NW'(CELL_IDX));
	assign full    = here && (cores_q >= CW'(MAX_CORES));
	assign sum_add = {1'b0, sum_q} + {5'b0, speed};
	assign prod    = PW'(instr) * PW'(cores_q);

	always_comb begin
		shifted = {rq_q[RW-2:0], 1'b0};
		hi      = shifted[RW-1:DW];
		rq_next = shifted;
		if (hi >= {1'b0, sum_q}) begin
			rq_next[RW-1:DW] = hi - {1'b0, sum_q};
			rq_next[0]       = 1'b1;
		end
	end

	always_comb begin
		tot    = SW'(rq_q[DW-1:0]) + SW'(fin_q);
		cand   = (tot > SW'(FIN_MAX)) ? FIN_MAX : tot[47:0];
		usable = (NW'(CELL_IDX) < n_used) && (cores_q != '0) && (sum_q != '0);
		best_d = best_in;
		if (usable && (!best_in.found || cand < best_in.fin)) begin
			best_d.found = 1'b1;
			best_d.idx   = MIDX_W'(CELL_IDX);
			best_d.fin   = cand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cores_q <= '0;
			sum_q   <= '0;
			fin_q   <= '0;
		end else if (ctrl.clr) begin
			cores_q <= '0;
			sum_q   <= '0;
			fin_q   <= '0;
		end else begin
			if (ctrl.add && here) begin
				cores_q <= cores_q + 1'b1;
				sum_q   <= sum_add[20] ? 20'hFFFFF : sum_add[19:0];
			end
			if (ctrl.wr && (wr_idx == MIDX_W'(CELL_IDX))) begin
				fin_q <= wr_fin;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			rq_q <= {21'b0, prod, {FRACTION_BITS{1'b0}}};
		end else if (ctrl.step) begin
			rq_q <= rq_next;
		end
		best_q <= best_d;
	end

	assign best_out = best_q;
endmodule
`default_nettype wire

// ===== hdl/earliest_finish_vm_scheduler_unit.sv =====
// Schedule beat: load of the product, bit-serial division into a quotient of
// 31+clog2(MAX_CORES+1)+FRACTION_BITS bits (52 by default), then the best candidate
// ripples down the cell chain to the output register. Add and clear beats skip both.
// One beat at a time; the output register lets a new beat enter while a result waits.
// Asynchronous reset zeroes the table and sets machines_in_use to 1. Uses efvs_pkg.
`default_nettype none
module earliest_finish_vm_scheduler_unit #(
	parameter int MAX_MACHINES  = efvs_pkg::MAX_MACHINES_DEF,
	parameter int MAX_CORES     = efvs_pkg::MAX_CORES_DEF,
	parameter int FRACTION_BITS = efvs_pkg::FRACTION_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	output logic                in_stall,
	input  efvs_pkg::in_beat_t  in_data,
	output logic                out_valid,
	input  wire                 out_stall,
	output efvs_pkg::out_beat_t out_data,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [2:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import efvs_pkg::*;

	localparam int CW   = $clog2(MAX_CORES + 1);
	localparam int DW   = 31 + CW + FRACTION_BITS;
	localparam int CNTW = $clog2(((DW > MAX_MACHINES) ? DW : MAX_MACHINES) + 2);
	localparam int RSW  = (((31 + FRACTION_BITS) > 48) ? (31 + FRACTION_BITS) : 48) + 2;

	logic [4:0]      miu_q;
	state_t          state_q, state_d;
	logic [CNTW-1:0] cnt_q, cnt_d;
	in_beat_t        beat_q;
	out_beat_t       res_q, res_d;
	out_beat_t       out_q;
	logic            out_valid_q;

	logic [NW-1:0]   n_used;
	cell_ctrl_t      ctrl;
	best_t           chain [MAX_MACHINES+1];
	logic [MAX_MACHINES-1:0] full_v;
	logic            accept, out_free;
	logic [3:0]      add_idx;
	logic signed [RSW-1:0] resp;

	assign pready = 1'b1;
	assign prdata = paddr[2] ? 32'd0 : {27'd0, miu_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			miu_q <= 5'd1;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			miu_q <= pwdata[4:0];
		end
	end

	always_comb begin
		if (miu_q == 5'd0) begin
			n_used = NW'(1);
		end else if ({2'b00, miu_q} > NW'(MAX_MACHINES)) begin
			n_used = NW'(MAX_MACHINES);
		end else begin
			n_used = {2'b00, miu_q};
		end
	end

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign add_idx  = accept ? in_data.machine_index : beat_q.machine_index;

	assign chain[0] = '0;
	for (genvar g = 0; g < MAX_MACHINES; g++) begin : g_cell
		efvs_cell #(
			.CELL_IDX(g),
			.MAX_CORES(MAX_CORES),
			.FRACTION_BITS(FRACTION_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.add_idx(add_idx),
			.speed(in_data.core_speed),
			.instr(beat_q.instruction_count),
			.wr_idx(chain[MAX_MACHINES].idx),
			.wr_fin(chain[MAX_MACHINES].fin),
			.n_used(n_used),
			.best_in(chain[g]),
			.best_out(chain[g+1]),
			.full(full_v[g])
		);
	end

	assign resp = RSW'(chain[MAX_MACHINES].fin)
		- RSW'({beat_q.start_time, {FRACTION_BITS{1'b0}}});

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		res_d   = res_q;
		ctrl    = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_d   = '0;
					state_d = S_DONE;
					case (in_data.command)
						CMD_ADD: begin
							if ({3'b000, in_data.machine_index} >= n_used) begin
								res_d.status = ST_RANGE;
							end else if (|full_v) begin
								res_d.status = ST_FULL;
							end else begin
								ctrl.add = 1'b1;
							end
						end
						CMD_SCHED: state_d = S_MUL;
						CMD_CLEAR: ctrl.clr = 1'b1;
						default: ;
					endcase
				end
			end
			S_MUL: begin
				ctrl.load = 1'b1;
				cnt_d     = '0;
				state_d   = S_DIV;
			end
			S_DIV: begin
				ctrl.step = 1'b1;
				cnt_d     = cnt_q + 1'b1;
				if (cnt_q == CNTW'(DW - 1)) begin
					cnt_d   = '0;
					state_d = S_CHAIN;
				end
			end
			S_CHAIN: begin
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNTW'(MAX_MACHINES)) begin
					state_d = S_DONE;
					if (chain[MAX_MACHINES].found) begin
						ctrl.wr              = 1'b1;
						res_d.status         = ST_OK;
						res_d.chosen_machine = chain[MAX_MACHINES].idx[3:0];
						res_d.finish_time    = chain[MAX_MACHINES].fin;
						if (resp > RSW'(48'sh7FFF_FFFF_FFFF)) begin
							res_d.response_time = 48'sh7FFF_FFFF_FFFF;
						end else if (resp < -RSW'(48'sh7FFF_FFFF_FFFF) - 1) begin
							res_d.response_time = 48'sh8000_0000_0000;
						end else begin
							res_d.response_time = resp[47:0];
						end
					end else begin
						res_d.status = ST_NONE;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
		if (accept) begin
			beat_q <= in_data;
		end
		if (state_q == S_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;
endmodule
`default_nettype wire

// ===== hdl/efvs_checker.sv =====
// Port-level checks for the scheduler top level, attached by bind.
// Uses efvs_pkg.
`default_nettype none
module efvs_checker (
	input wire                 clk,
	input wire                 arst_n,
	input wire                 in_valid,
	input wire                 in_stall,
	input efvs_pkg::out_beat_t out_data,
	input wire                 out_valid,
	input wire                 out_stall
);
	import efvs_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second beat taken while one is in work");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.status == ST_RANGE || out_data.status == ST_FULL
			|| out_data.status == ST_NONE)
		|-> out_data.chosen_machine == 4'd0 && out_data.finish_time == 48'd0
			&& out_data.response_time == 48'sd0)
		else $error("error result carries nonzero fields");
endmodule

bind earliest_finish_vm_scheduler_unit efvs_checker u_efvs_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_data(out_data),
	.out_valid(out_valid),
	.out_stall(out_stall)
);
`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the earliest-finish machine scheduler unit.
// Predicts every result from a local copy of the machine table and register;
// depends on efvs_pkg and earliest_finish_vm_scheduler_unit only.
`default_nettype none

class sched_board;
	logic [47:0] finish_q [16];
	logic [4:0]  cores_q [16];
	logic [19:0] speed_q [16];
	logic [4:0]  in_use;
	efvs_pkg::out_beat_t pending[$];
	int mismatches;

	function new();
		mismatches = 0;
		in_use = 5'd1;
		wipe_table();
	endfunction

	function void wipe_table();
		for (int j = 0; j < 16; j++) begin
			finish_q[j] = '0;
			cores_q[j] = '0;
			speed_q[j] = '0;
		end
	endfunction

	function void note_beat(efvs_pkg::in_beat_t b);
		efvs_pkg::out_beat_t r;
		int n;
		logic found;
		int best;
		logic [47:0] best_fin;
		logic [127:0] cost;
		logic [127:0] fin;
		logic [20:0] s;
		logic signed [63:0] resp;
		r = '0;
		n = (in_use < 1) ? 1 : ((in_use > 16) ? 16 : int'(in_use));
		found = 1'b0;
		best = 0;
		best_fin = '0;
		case (efvs_pkg::cmd_t'(b.command))
			efvs_pkg::CMD_ADD: begin
				if (b.machine_index >= n) r.status = efvs_pkg::ST_RANGE;
				else if (cores_q[b.machine_index] >= 16) r.status = efvs_pkg::ST_FULL;
				else begin
					s = speed_q[b.machine_index] + b.core_speed;
					cores_q[b.machine_index] += 1;
					speed_q[b.machine_index] = s[20] ? 20'hFFFFF : s[19:0];
				end
			end
			efvs_pkg::CMD_SCHED: begin
				for (int j = 0; j < n; j++) begin
					if (cores_q[j] == 0 || speed_q[j] == 0) continue;
					cost = ((128'(b.instruction_count) * cores_q[j]) << 16) / speed_q[j];
					fin = 128'(finish_q[j]) + cost;
					if (fin > 128'(efvs_pkg::FIN_MAX)) fin = 128'(efvs_pkg::FIN_MAX);
					if (!found || fin[47:0] < best_fin) begin
						found = 1'b1;
						best = j;
						best_fin = fin[47:0];
					end
				end
				if (!found) r.status = efvs_pkg::ST_NONE;
				else begin
					finish_q[best] = best_fin;
					resp = $signed({16'd0, best_fin}) - $signed(64'(b.start_time) << 16);
					if (resp > 64'sh7FFF_FFFF_FFFF) resp = 64'sh7FFF_FFFF_FFFF;
					r.chosen_machine = best[3:0];
					r.finish_time = best_fin;
					r.response_time = resp[47:0];
				end
			end
			efvs_pkg::CMD_CLEAR: wipe_table();
			default: ;
		endcase
		pending.push_back(r);
	endfunction

	function void check_beat(efvs_pkg::out_beat_t got);
		efvs_pkg::out_beat_t want;
		if (pending.size() == 0) begin
			mismatches++;
			if (mismatches <= 10) $display("unexpected result %h", got);
			return;
		end
		want = pending.pop_front();
		if (got.status !== want.status || got.chosen_machine !== want.chosen_machine ||
				got.finish_time !== want.finish_time ||
				got.response_time !== want.response_time) begin
			mismatches++;
			if (mismatches <= 10)
				$display("mismatch: expected st=%0d m=%0d f=%h r=%h got st=%0d m=%0d f=%h r=%h",
					want.status, want.chosen_machine, want.finish_time, want.response_time,
					got.status, got.chosen_machine, got.finish_time, got.response_time);
		end
	endfunction
endclass

module testbench;
	import efvs_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	in_beat_t in_data = '0;
	logic out_valid;
	logic out_stall = 0;
	out_beat_t out_data;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	sched_board board = new();
	int idle_cycles = 0;
	logic quiet = 0;
	logic hold_long = 0;
	logic drain = 0;
	int hold_len = 0;

	localparam int WATCHDOG = 20000;

	earliest_finish_vm_scheduler_unit i_dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
		.out_data(out_data), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		if (in_valid && !in_stall) board.note_beat(in_data);
		if (out_valid && !out_stall) board.check_beat(out_data);
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random stall bursts, one long hold-off on request
	always @(posedge clk) begin
		if (hold_long) begin
			out_stall <= 1;
			hold_len <= hold_len + 1;
			if (hold_len >= 400) begin
				hold_long <= 0;
				hold_len <= 0;
			end
		end else if (quiet) out_stall <= 0;
		else if (hold_len > 0) hold_len <= hold_len - 1;
		else if ($urandom_range(0, 5) == 0) begin
			out_stall <= ~out_stall;
			hold_len <= $urandom_range(1, 13);
		end
	end

	task automatic write_reg(input logic [4:0] val);
		@(posedge clk);
		psel <= 1; pwrite <= 1; penable <= 0; paddr <= '0; pwdata <= 32'(val);
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		board.in_use = val;
	endtask

	task automatic send_beat(input in_beat_t b);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid <= 1;
		in_data <= b;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic settle();
		in_valid <= 0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	function automatic in_beat_t rand_beat(input int bias);
		in_beat_t b;
		int k;
		b.command = (bias == 0) ? CMD_ADD : CMD_SCHED;
		k = $urandom_range(0, 19);
		if (k == 0) b.command = CMD_CLEAR;
		else if (k == 1) b.command = CMD_NONE;
		else if (k < 8) b.command = CMD_ADD;
		b.machine_index = 4'($urandom_range(0, 15));
		b.core_speed = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom);
		b.instruction_count = ($urandom_range(0, 4) == 0) ? 31'($urandom_range(0, 100))
			: 31'($urandom);
		b.start_time = 31'($urandom);
		return b;
	endfunction

	function automatic in_beat_t mk(input cmd_t c, input int idx, input logic [15:0] sp,
			input logic [30:0] ic, input logic [30:0] st);
		in_beat_t b;
		b.command = c; b.machine_index = 4'(idx); b.core_speed = sp;
		b.instruction_count = ic; b.start_time = st;
		return b;
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty table, range error, full machine, maximum operands, clear, ignored command
		send_beat(mk(CMD_SCHED, 0, 0, 31'h7FFFFFFF, 0));
		send_beat(mk(CMD_ADD, 1, 5, 0, 0));
		send_beat(mk(CMD_ADD, 0, 0, 0, 0));
		send_beat(mk(CMD_SCHED, 0, 0, 100, 0));
		send_beat(mk(CMD_NONE, 15, 16'hFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF));
		settle();
		write_reg(5'd16);
		for (int j = 0; j < 17; j++) send_beat(mk(CMD_ADD, 15, 16'hFFFF, 0, 0));
		send_beat(mk(CMD_ADD, 3, 1, 0, 0));
		send_beat(mk(CMD_SCHED, 0, 0, 31'h7FFFFFFF, 31'h7FFFFFFF));
		send_beat(mk(CMD_SCHED, 0, 0, 31'h7FFFFFFF, 0));
		send_beat(mk(CMD_SCHED, 0, 0, 0, 31'h7FFFFFFF));
		send_beat(mk(CMD_CLEAR, 0, 0, 0, 0));
		send_beat(mk(CMD_SCHED, 0, 0, 1, 1));
		settle();
		write_reg(5'd0);
		send_beat(mk(CMD_ADD, 0, 7, 0, 0));
		send_beat(mk(CMD_SCHED, 0, 0, 1000, 3));
		settle();
		write_reg(5'd31);
		send_beat(mk(CMD_ADD, 15, 9, 0, 0));
		settle();

		// random phases at several register settings
		for (int ph = 0; ph < 5; ph++) begin
			write_reg((ph == 0) ? 5'd16 : (ph == 4) ? 5'd1 : 5'($urandom_range(1, 16)));
			if (ph == 1) begin
				hold_long <= 1;
			end
			if (ph == 4) quiet = 1;
			for (int i = 0; i < 150; i++) begin
				send_beat(rand_beat(i < 25 ? 0 : 1));
				if (i == 75 && ph == 2) settle();
			end
			settle();
		end

		if (board.mismatches == 0 && board.pending.size() == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule
`default_nettype wire
